>>> hdl/qslerp_pkg.sv
// Shared types, widths and constant tables for the quaternion slerp pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qslerp_pkg;

   // CORDIC datapath width: holds gain growth of Q30 vectors and the angle sum
   localparam int CW = 34;
   typedef logic signed [CW-1:0] cval_type;

   // square root: 61-bit radicand, 31-bit root, one root bit per stage
   localparam int RAD_W    = 61;
   localparam int ROOT_W   = 31;
   localparam int SQ_STEPS = 31;
   localparam int SQ_RW    = 33;

   // divider: (sine << 30) / s, quotient bounded below 2^38 on the slerp path
   localparam int NUM_W = 61;
   localparam int DEN_W = 31;
   localparam int QW    = 38;

   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam cval_type    CORDIC_GAIN = 34'h0_26DD_3B6A;
   // 0.9999 * 10000 * 2^30, threshold for linear weights
   localparam logic [43:0] LIN_LIMIT   = 44'd10736344498176;

   typedef struct packed {
      logic [3:0][15:0] a;     // q0, index 0 = w
      logic [3:0][16:0] b;     // q1 after sign fix
      logic [16:0]      t;
      logic             lin;   // linear weights
      logic             byp0;  // t == 0
      logic             byp1;  // t >= 1.0
   } side_type;

   // arctangent of 2^-k, Q30, truncated
   function automatic logic [29:0] atan_entry(input logic [4:0] k);
      logic [29:0] v;
      case (k)
         5'd0:  v = 30'h3243F6A8;
         5'd1:  v = 30'h1DAC6705;
         5'd2:  v = 30'h0FADBAFC;
         5'd3:  v = 30'h07F56EA6;
         5'd4:  v = 30'h03FEAB76;
         5'd5:  v = 30'h01FFD55B;
         5'd6:  v = 30'h00FFFAAA;
         5'd7:  v = 30'h007FFF55;
         5'd8:  v = 30'h003FFFEA;
         5'd9:  v = 30'h001FFFFD;
         5'd10: v = 30'h000FFFFF;
         5'd11: v = 30'h0007FFFF;
         5'd12: v = 30'h0003FFFF;
         5'd13: v = 30'h0001FFFF;
         5'd14: v = 30'h0000FFFF;
         5'd15: v = 30'h00007FFF;
         5'd16: v = 30'h00003FFF;
         5'd17: v = 30'h00001FFF;
         5'd18: v = 30'h00000FFF;
         5'd19: v = 30'h000007FF;
         5'd20: v = 30'h000003FF;
         5'd21: v = 30'h000001FF;
         5'd22: v = 30'h000000FF;
         5'd23: v = 30'h0000007F;
         5'd24: v = 30'h0000003F;
         5'd25: v = 30'h0000001F;
         5'd26: v = 30'h0000000F;
         5'd27: v = 30'h00000007;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> hdl/qslerp_delay.sv
// Enabled shift line that carries side data alongside the arithmetic units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_delay #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] din,
   output logic      [W-1:0] dout
);

   logic [W-1:0] line_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < D; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[D-1];

endmodule

`default_nettype wire

>>> hdl/qslerp_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_sqrt (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [qslerp_pkg::RAD_W-1:0]   rad,
   output logic      [qslerp_pkg::ROOT_W-1:0]  root
);

   import qslerp_pkg::*;

   logic [SQ_RW-1:0]   rem_ff [SQ_STEPS];
   logic [ROOT_W-1:0]  q_ff   [SQ_STEPS];
   logic [2*SQ_STEPS-1:0] r_ff [SQ_STEPS];

   genvar i;
   for (i = 0; i < SQ_STEPS; i++) begin : g_step
      logic [SQ_RW-1:0]      remp, rem_in;
      logic [ROOT_W-1:0]     qp, q_in;
      logic [2*SQ_STEPS-1:0] rp, r_in;
      logic [SQ_RW+1:0]      remx, trial;
      logic                  ge;

      if (i == 0) begin : g_first
         assign remp = '0;
         assign qp   = '0;
         assign rp   = {1'b0, rad};
      end else begin : g_next
         assign remp = rem_ff[i-1];
         assign qp   = q_ff[i-1];
         assign rp   = r_ff[i-1];
      end

      always_comb begin
         remx   = {remp, rp[2*SQ_STEPS-1 -: 2]};
         trial  = {2'b00, qp, 2'b01};
         ge     = (remx >= trial);
         rem_in = ge ? SQ_RW'(remx - trial) : remx[SQ_RW-1:0];
         q_in   = {qp[ROOT_W-2:0], ge};
         r_in   = {rp[2*SQ_STEPS-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            q_ff[i]   <= q_in;
            r_ff[i]   <= r_in;
         end
      end
   end

   assign root = q_ff[SQ_STEPS-1];

endmodule

`default_nettype wire

>>> hdl/qslerp_cordic.sv
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_cordic #(
   parameter int STEPS  = 16,
   parameter bit ROTATE = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire qslerp_pkg::cval_type  x0,
   input  wire qslerp_pkg::cval_type  y0,
   input  wire qslerp_pkg::cval_type  z0,
   output qslerp_pkg::cval_type       res
);

   import qslerp_pkg::*;

   cval_type x_ff [STEPS];
   cval_type y_ff [STEPS];
   cval_type z_ff [STEPS];

   genvar i;
   for (i = 0; i < STEPS; i++) begin : g_step
      cval_type xp, yp, zp, dx, dy, at, x_in, y_in, z_in;
      logic     turn;

      if (i == 0) begin : g_first
         assign xp = x0;
         assign yp = y0;
         assign zp = z0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      assign at = {{(CW-30){1'b0}}, atan_entry(5'(i))};
      assign dx = yp >>> i;
      assign dy = xp >>> i;
      // vectoring drives y to zero, rotation drives z to zero
      assign turn = ROTATE ? zp[CW-1] : (!yp[CW-1] && (yp != '0));

      always_comb begin
         if (turn) begin
            x_in = xp + dx;
            y_in = yp - dy;
            z_in = zp + at;
         end else begin
            x_in = xp - dx;
            y_in = yp + dy;
            z_in = zp - at;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign res = ROTATE ? y_ff[STEPS-1] : z_ff[STEPS-1];

endmodule

`default_nettype wire

>>> hdl/qslerp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_div (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [qslerp_pkg::NUM_W-1:0]  num,
   input  wire logic [qslerp_pkg::DEN_W-1:0]  den,
   output logic      [qslerp_pkg::QW-1:0]     quo
);

   import qslerp_pkg::*;

   logic [DEN_W-1:0] rem_ff [QW];
   logic [QW-1:0]    nq_ff  [QW];   // dividend bits out, quotient bits in
   logic [DEN_W-1:0] d_ff   [QW];

   genvar i;
   for (i = 0; i < QW; i++) begin : g_step
      logic [DEN_W-1:0] remp, dp, rem_in;
      logic [QW-1:0]    nqp, nq_in;
      logic [DEN_W:0]   rx;
      logic             ge;

      if (i == 0) begin : g_first
         assign remp = {{(DEN_W-NUM_W+QW){1'b0}}, num[NUM_W-1:QW]};
         assign nqp  = num[QW-1:0];
         assign dp   = den;
      end else begin : g_next
         assign remp = rem_ff[i-1];
         assign nqp  = nq_ff[i-1];
         assign dp   = d_ff[i-1];
      end

      always_comb begin
         rx     = {remp, nqp[QW-1]};
         ge     = (rx >= {1'b0, dp});
         rem_in = ge ? DEN_W'(rx - {1'b0, dp}) : rx[DEN_W-1:0];
         nq_in  = {nqp[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            nq_ff[i]  <= nq_in;
            d_ff[i]   <= dp;
         end
      end
   end

   assign quo = nq_ff[QW-1];

endmodule

`default_nettype wire

>>> hdl/quaternion_slerp.sv
// Quaternion slerp top level: front end, CORDIC/sqrt/divide chain, blend.
// Depends on qslerp_pkg, qslerp_delay, qslerp_sqrt, qslerp_cordic, qslerp_div.
//
//   channel  | dir | handshake             | beat
//   req_     | in  | req_valid / req_ready | q0, q1 (Q2.14), fraction (Q1.16)
//   rsp_     | out | rsp_valid / rsp_ready | out_w..out_z (Q2.14, saturated)
//
// One beat in and one beat out per cycle while the pipe is not held.
// Stages in order: 3 front, 31 sqrt, CORDIC vectoring, angle scale, CORDIC
// rotation, 38 divide, 4 blend. The whole pipe advances together; it holds
// while a result sits in the output register and rsp_ready is low, and
// req_ready follows.
// Synchronous reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_slerp #(
   parameter int FRAC_BITS    = 14,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_q0_w,
   input  wire logic signed [15:0] req_q0_x,
   input  wire logic signed [15:0] req_q0_y,
   input  wire logic signed [15:0] req_q0_z,
   input  wire logic signed [15:0] req_q1_w,
   input  wire logic signed [15:0] req_q1_x,
   input  wire logic signed [15:0] req_q1_y,
   input  wire logic signed [15:0] req_q1_z,
   input  wire logic        [16:0] req_fraction,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed      [15:0] rsp_out_w,
   output logic signed      [15:0] rsp_out_x,
   output logic signed      [15:0] rsp_out_y,
   output logic signed      [15:0] rsp_out_z
);

   import qslerp_pkg::*;

   // dot product is Q(2*FRAC_BITS); align to Q30
   localparam int SH     = 2 * FRAC_BITS - 30;
   localparam int SHR    = (SH >= 0) ? SH : 0;
   localparam int SHL    = (SH < 0) ? -SH : 0;
   localparam int LAT    = 39 + 2 * CORDIC_STEPS + QW;
   localparam int D_SIDE = 32 + 2 * CORDIC_STEPS + QW;
   localparam int PW     = QW + 18;   // blend product width

   // ---------------------------------------------------------------
   // flow control: one global advance, valid bits ride a shift line
   // ---------------------------------------------------------------
   logic           en;
   logic [LAT-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: capture, four component products
   // ---------------------------------------------------------------
   logic [3:0][15:0] a1_ff, a1_in, b1_ff, b1_in;
   logic [3:0][31:0] p1_ff, p1_in;
   logic [16:0]      t1_ff;
   logic             byp0_1_ff, byp1_1_ff;

   always_comb begin
      a1_in = {req_q0_z, req_q0_y, req_q0_x, req_q0_w};
      b1_in = {req_q1_z, req_q1_y, req_q1_x, req_q1_w};
      for (int j = 0; j < 4; j++) begin
         p1_in[j] = {{16{a1_in[j][15]}}, a1_in[j]} * {{16{b1_in[j][15]}}, b1_in[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff     <= a1_in;
         b1_ff     <= b1_in;
         p1_ff     <= p1_in;
         t1_ff     <= req_fraction;
         byp0_1_ff <= (req_fraction == '0);
         byp1_1_ff <= req_fraction[16];
      end
   end

   // ---------------------------------------------------------------
   // stage 2: dot sum, hemisphere fix, cosine in Q30
   // ---------------------------------------------------------------
   logic [33:0]      dot2;
   logic             neg2;
   logic [32:0]      dabs2;
   logic [43:0]      cw2;
   logic [30:0]      c2_ff, c2_in;
   logic [3:0][15:0] a2_ff;
   logic [3:0][16:0] b2_ff, b2_in;
   logic [16:0]      t2_ff;
   logic             byp0_2_ff, byp1_2_ff;

   always_comb begin
      dot2 = '0;
      for (int j = 0; j < 4; j++) begin
         dot2 = dot2 + {{2{p1_ff[j][31]}}, p1_ff[j]};
      end
      neg2  = dot2[33];
      dabs2 = neg2 ? 33'(~dot2 + 34'd1) : dot2[32:0];
      cw2   = ({11'b0, dabs2} >> SHR) << SHL;
      c2_in = (cw2 > {13'b0, ONE_Q30}) ? ONE_Q30 : cw2[30:0];
      // q1 is returned untouched for t of 1.0, so no flip there
      for (int j = 0; j < 4; j++) begin
         b2_in[j] = (neg2 && !byp1_1_ff) ? 17'(~{b1_ff[j][15], b1_ff[j]} + 17'd1)
                                         : {b1_ff[j][15], b1_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff     <= c2_in;
         a2_ff     <= a1_ff;
         b2_ff     <= b2_in;
         t2_ff     <= t1_ff;
         byp0_2_ff <= byp0_1_ff;
         byp1_2_ff <= byp1_1_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: c^2 for the sine, linear-region compare
   // ---------------------------------------------------------------
   logic [61:0]    csq_full;
   logic [43:0]    c10k;
   logic [60:0]    csq3_ff;
   logic [30:0]    c3_ff;
   side_type       side3_ff, side3_in;

   always_comb begin
      csq_full      = {31'b0, c2_ff} * {31'b0, c2_ff};
      c10k          = {13'b0, c2_ff} * 44'd10000;
      side3_in.a    = a2_ff;
      side3_in.b    = b2_ff;
      side3_in.t    = t2_ff;
      side3_in.lin  = (c10k > LIN_LIMIT);
      side3_in.byp0 = byp0_2_ff;
      side3_in.byp1 = byp1_2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         csq3_ff  <= csq_full[60:0];
         c3_ff    <= c2_ff;
         side3_ff <= side3_in;
      end
   end

   // ---------------------------------------------------------------
   // s = floor(sqrt(2^60 - c^2))
   // ---------------------------------------------------------------
   logic [RAD_W-1:0]  rad;
   logic [ROOT_W-1:0] s_root, c_d;

   assign rad = {1'b1, 60'b0} - csq3_ff;

   qslerp_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad),
      .root  (s_root)
   );

   qslerp_delay #(.W(31), .D(SQ_STEPS)) u_c_dly (
      .clock (clock), .en (en), .din (c3_ff), .dout (c_d)
   );

   // ---------------------------------------------------------------
   // w = atan2(s, c) by vectoring
   // ---------------------------------------------------------------
   cval_type w_z;

   qslerp_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b0)) u_vec (
      .clock (clock),
      .en    (en),
      .x0    ({3'b0, c_d}),
      .y0    ({3'b0, s_root}),
      .z0    ('0),
      .res   (w_z)
   );

   logic [16:0] t_m;

   qslerp_delay #(.W(17), .D(SQ_STEPS + CORDIC_STEPS)) u_t_dly (
      .clock (clock), .en (en), .din (side3_ff.t), .dout (t_m)
   );

   // ---------------------------------------------------------------
   // angle scale: w*t and w*(1-t)
   // ---------------------------------------------------------------
   logic [30:0] w_u, th0_ff, th1_ff;
   logic [47:0] th0_full, th1_full;

   always_comb begin
      w_u      = w_z[CW-1] ? 31'd0 : w_z[30:0];
      th1_full = {17'b0, w_u} * {31'b0, t_m};
      th0_full = {17'b0, w_u} * {31'b0, 17'(17'h10000 - t_m)};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         th0_ff <= th0_full[46:16];
         th1_ff <= th1_full[46:16];
      end
   end

   // ---------------------------------------------------------------
   // sines by rotation
   // ---------------------------------------------------------------
   cval_type sin0_y, sin1_y;

   qslerp_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b1)) u_rot0 (
      .clock (clock), .en (en),
      .x0 (CORDIC_GAIN), .y0 ('0), .z0 ({3'b0, th0_ff}), .res (sin0_y)
   );

   qslerp_cordic #(.STEPS(CORDIC_STEPS), .ROTATE(1'b1)) u_rot1 (
      .clock (clock), .en (en),
      .x0 (CORDIC_GAIN), .y0 ('0), .z0 ({3'b0, th1_ff}), .res (sin1_y)
   );

   logic [ROOT_W-1:0] s_d;

   qslerp_delay #(.W(ROOT_W), .D(2 * CORDIC_STEPS + 1)) u_s_dly (
      .clock (clock), .en (en), .din (s_root), .dout (s_d)
   );

   // ---------------------------------------------------------------
   // weights = sine * 2^30 / s
   // ---------------------------------------------------------------
   function automatic logic [30:0] clamp_sine(input cval_type y);
      logic [30:0] r;
      if (y[CW-1]) begin
         r = '0;
      end else if (y > {3'b0, ONE_Q30}) begin
         r = ONE_Q30;
      end else begin
         r = y[30:0];
      end
      return r;
   endfunction

   logic [DEN_W-1:0] den;
   logic [QW-1:0]    kq0, kq1;

   assign den = (s_d == '0) ? DEN_W'(1) : s_d;

   qslerp_div u_div0 (
      .clock (clock), .en (en),
      .num ({clamp_sine(sin0_y), 30'b0}), .den (den), .quo (kq0)
   );

   qslerp_div u_div1 (
      .clock (clock), .en (en),
      .num ({clamp_sine(sin1_y), 30'b0}), .den (den), .quo (kq1)
   );

   side_type side_k;

   qslerp_delay #(.W($bits(side_type)), .D(D_SIDE)) u_side_dly (
      .clock (clock), .en (en), .din (side3_ff), .dout (side_k)
   );

   // ---------------------------------------------------------------
   // blend: pick weights, multiply, sum with rounding, saturate
   // ---------------------------------------------------------------
   logic [QW-1:0]    k0_ff, k0_in, k1_ff, k1_in;
   logic [3:0][15:0] ak_ff;
   logic [3:0][16:0] bk_ff;

   always_comb begin
      if (side_k.byp0) begin
         k0_in = QW'(ONE_Q30);
         k1_in = '0;
      end else if (side_k.byp1) begin
         k0_in = '0;
         k1_in = QW'(ONE_Q30);
      end else if (side_k.lin) begin
         k0_in = QW'({17'(17'h10000 - side_k.t), 14'b0});
         k1_in = QW'({side_k.t, 14'b0});
      end else begin
         k0_in = kq0;
         k1_in = kq1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k0_ff <= k0_in;
         k1_ff <= k1_in;
         ak_ff <= side_k.a;
         bk_ff <= side_k.b;
      end
   end

   logic [3:0][PW-1:0] pa_ff, pa_in, pb_ff, pb_in;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         pa_in[j] = {{(PW-QW){1'b0}}, k0_ff} * {{(PW-16){ak_ff[j][15]}}, ak_ff[j]};
         pb_in[j] = {{(PW-QW){1'b0}}, k1_ff} * {{(PW-17){bk_ff[j][16]}}, bk_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

   logic [3:0][PW-1:0] acc_ff, acc_in;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         acc_in[j] = pa_ff[j] + pb_ff[j] + (PW'(1) << 29);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

   logic [3:0][15:0]    out_ff, out_in;
   logic [3:0][PW-31:0] hi;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         hi[j] = acc_ff[j][PW-1:30];
         if (hi[j][PW-31:15] == '0 || hi[j][PW-31:15] == '1) begin
            out_in[j] = hi[j][15:0];
         end else if (hi[j][PW-31]) begin
            out_in[j] = 16'h8000;
         end else begin
            out_in[j] = 16'h7FFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_out_w = out_ff[0];
   assign rsp_out_x = out_ff[1];
   assign rsp_out_y = out_ff[2];
   assign rsp_out_z = out_ff[3];

endmodule

`default_nettype wire
